/* src/fmbq_pkg.sv */
// ----------------------------------------------------------------------------
// Front/middle/back queue package
// Shared types and constants for the queue cell chain and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fmbq_pkg;

   // Width of one stored value.
   localparam int DATA_W = 32;

   // Width of a cell position.
   // It covers the largest supported queue depth of 1024 entries.
   localparam int POS_W = 10;

   // Number of cells gathered by one first-level OR group on a pop.
   localparam int GROUP_SIZE = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT  = 3'd0,
      OP_PUSH_MIDDLE = 3'd1,
      OP_PUSH_BACK   = 3'd2,
      OP_POP_FRONT   = 3'd3,
      OP_POP_MIDDLE  = 3'd4,
      OP_POP_BACK    = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      cell_op_type      op;
      logic [POS_W-1:0] pos;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* src/fmbq_cell.sv */
// ----------------------------------------------------------------------------
// Queue cell
// Holds one queue entry; shifts toward or away from its neighbors on command.
// ----------------------------------------------------------------------------
`default_nettype none

module fmbq_cell
   import fmbq_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  wire                clock,
   input  cell_ctrl_type      ctrl,
   input  wire  [DATA_W-1:0]  push_value,
   input  wire  [DATA_W-1:0]  left_value,
   input  wire  [DATA_W-1:0]  right_value,
   output logic [DATA_W-1:0]  entry_value,
   output logic [DATA_W-1:0]  pick_value
);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic              at_pos;
   logic              past_pos;

   assign at_pos   = (ctrl.pos == POS_W'(INDEX));
   assign past_pos = (POS_W'(INDEX) > ctrl.pos);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (at_pos) begin
               entry_in = push_value;
            end else if (past_pos) begin
               entry_in = left_value;
            end
         end
         CELL_REMOVE: begin
            if (at_pos || past_pos) begin
               entry_in = right_value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   // The removed entry shows here; every other cell shows zero so the
   // values can be ORed together.
   assign pick_value  = (ctrl.op == CELL_REMOVE && at_pos) ? entry_ff : '0;

endmodule

`default_nettype wire

/* src/front_middle_back_queue.sv */
// ----------------------------------------------------------------------------
// Front/middle/back queue
// Bounded ordered queue of signed 32-bit values with push and pop at the
// front, the middle and the back, built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// A request carries an opcode and a value on req_opcode and req_data_value.
// It is taken at a rising edge with req_valid high and req_stall low. Every
// request gives exactly one response on rsp_popped_value and rsp_status,
// taken at an edge with rsp_valid high and rsp_stall low.
// A middle push inserts at index floor(n/2); a middle pop removes index
// floor((n-1)/2). A pop on an empty queue answers status empty, a push on
// a full queue is dropped with status full, and opcodes six and seven do
// nothing and answer ok. The popped value is zero unless a pop succeeds.
// A request passes the gather stage and then the response register. One
// request is taken every cycle unless req_stall is high: all cells shift
// in the cycle the request is taken, and the removed value is gathered by
// a two-level registered OR tree, groups of 32 cells first and then the
// group results. Reset clears the entry count and both pipeline stages;
// the queue is empty afterwards and needs no clearing pass. While the
// receiver stalls, the response holds, one more request fills the gather
// stage, and then req_stall rises until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module front_middle_back_queue
   import fmbq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire         [2:0]        req_opcode,
   input  wire  signed [DATA_W-1:0] req_data_value,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic signed [DATA_W-1:0] rsp_popped_value,
   output logic        [1:0]        rsp_status
);

   // The count needs one more code than the positions, to hold a full queue.
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_GROUPS = (QUEUE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   // Entry count and control of the two pipeline stages.
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   status_type        s1_status_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [DATA_W-1:0] rsp_value_in;

   // First-level OR results, one per group of cells.
   logic [DATA_W-1:0] group_ff [NUM_GROUPS];
   logic [DATA_W-1:0] group_in [NUM_GROUPS];

   logic              req_fire;
   logic              s1_advance;
   logic              queue_full;
   logic              queue_empty;
   logic [CNT_W-1:0]  count_m1;
   status_type        status_next;
   cell_ctrl_type     cell_ctrl;

   logic [DATA_W-1:0] entry_value [QUEUE_DEPTH];
   logic [DATA_W-1:0] pick_value  [QUEUE_DEPTH];

   // ------------------------------------------------------------------------
   // Handshakes. The gather stage moves on whenever the response register is
   // free or being emptied; a new request is taken whenever the gather stage
   // is free or moving on.
   // ------------------------------------------------------------------------
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_fire   = req_valid && !req_stall;

   // ------------------------------------------------------------------------
   // Decode of the request into one command for the whole cell chain.
   // ------------------------------------------------------------------------
   assign queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign count_m1    = count_ff - 1'b1;

   always_comb begin
      cell_ctrl.op  = CELL_HOLD;
      cell_ctrl.pos = '0;
      status_next   = ST_OK;
      case (req_opcode)
         OP_PUSH_FRONT: begin
            if (queue_full) begin
               status_next = ST_FULL;
            end else begin
               cell_ctrl.op = CELL_INSERT;
            end
         end
         OP_PUSH_MIDDLE: begin
            if (queue_full) begin
               status_next = ST_FULL;
            end else begin
               cell_ctrl.op  = CELL_INSERT;
               cell_ctrl.pos = POS_W'(count_ff >> 1);
            end
         end
         OP_PUSH_BACK: begin
            if (queue_full) begin
               status_next = ST_FULL;
            end else begin
               cell_ctrl.op  = CELL_INSERT;
               cell_ctrl.pos = POS_W'(count_ff);
            end
         end
         OP_POP_FRONT: begin
            if (queue_empty) begin
               status_next = ST_EMPTY;
            end else begin
               cell_ctrl.op = CELL_REMOVE;
            end
         end
         OP_POP_MIDDLE: begin
            if (queue_empty) begin
               status_next = ST_EMPTY;
            end else begin
               cell_ctrl.op  = CELL_REMOVE;
               cell_ctrl.pos = POS_W'(count_m1 >> 1);
            end
         end
         OP_POP_BACK: begin
            if (queue_empty) begin
               status_next = ST_EMPTY;
            end else begin
               cell_ctrl.op  = CELL_REMOVE;
               cell_ctrl.pos = POS_W'(count_m1);
            end
         end
         default: begin
            cell_ctrl.op = CELL_HOLD;
         end
      endcase
      // The chain only moves on a request that is really taken.
      if (!req_fire) begin
         cell_ctrl.op = CELL_HOLD;
      end
   end

   always_comb begin
      case (cell_ctrl.op)
         CELL_INSERT: count_in = count_ff + 1'b1;
         CELL_REMOVE: count_in = count_m1;
         default:     count_in = count_ff;
      endcase
   end

   // ------------------------------------------------------------------------
   // The cell chain. Each cell sees its left and right neighbor; the first
   // cell's left input is never selected, and the last cell sees itself.
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_value;
      logic [DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = req_data_value;
      end else begin : g_inner_left
         assign left_value = entry_value[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_value = entry_value[i];
      end else begin : g_inner_right
         assign right_value = entry_value[i+1];
      end

      fmbq_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .push_value  (req_data_value),
         .left_value  (left_value),
         .right_value (right_value),
         .entry_value (entry_value[i]),
         .pick_value  (pick_value[i])
      );
   end

   // ------------------------------------------------------------------------
   // Gather of the removed value: each group ORs the pick outputs of its
   // cells, taken before the chain shifts. At most one cell is nonzero.
   // ------------------------------------------------------------------------
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      logic [DATA_W-1:0] member [GROUP_SIZE];

      for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_member
         if (g * GROUP_SIZE + k < QUEUE_DEPTH) begin : g_used
            assign member[k] = pick_value[g * GROUP_SIZE + k];
         end else begin : g_unused
            assign member[k] = '0;
         end
      end

      always_comb begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            group_in[g] = group_in[g] | member[k];
         end
      end

      always_ff @(posedge clock) begin
         if (req_fire) begin
            group_ff[g] <= group_in[g];
         end
      end
   end

   // Second level: OR of the group results into the response register.
   always_comb begin
      rsp_value_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         rsp_value_in = rsp_value_in | group_ff[g];
      end
   end

   // ------------------------------------------------------------------------
   // Stage valid flags and the count.
   // ------------------------------------------------------------------------
   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_status_ff <= status_next;
      end
      if (s1_advance) begin
         rsp_status_ff <= s1_status_ff;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count exceeds the queue depth");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (cell_ctrl.op == CELL_INSERT) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not raise the entry count by one");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (cell_ctrl.op == CELL_REMOVE) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("remove did not lower the entry count by one");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_value_ff == '0))
      else $error("failed request returned a nonzero value");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled while a pipeline stage was free");

endmodule

`default_nettype wire

/* sim/front_middle_back_queue_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front/middle/back queue checker
// Watches the request and response channels, keeps its own copy of the
// queue, and compares every response with the prediction made for it.
// ----------------------------------------------------------------------------

module front_middle_back_queue_check
   import fmbq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_stall,
   input  wire         [2:0]        req_opcode,
   input  wire  signed [DATA_W-1:0] req_data_value,
   input  wire                      rsp_valid,
   input  wire                      rsp_stall,
   input  wire  signed [DATA_W-1:0] rsp_popped_value,
   input  wire         [1:0]        rsp_status,
   output int                       fail_count,
   output int                       owed_count,
   output int                       checked_count,
   output int                       empty_count,
   output int                       full_count,
   output int                       peak_fill
);

   typedef struct {
      logic signed [DATA_W-1:0] popped_value;
      status_type               status;
   } queue_result_type;

   // Index 0 is the front of the queue.
   logic signed [DATA_W-1:0] stored_values[$];
   queue_result_type         owed_results[$];

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic apply_queue_op(input logic [2:0] op,
                                 input logic signed [DATA_W-1:0] value,
                                 output queue_result_type outcome);
      int n;
      int idx;
      outcome.popped_value = '0;
      outcome.status       = ST_OK;
      n = stored_values.size();
      case (op)
         OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
            if (n >= QUEUE_DEPTH) begin
               outcome.status = ST_FULL;
               full_count++;
            end else if (op == OP_PUSH_FRONT) begin
               stored_values.insert(0, value);
            end else if (op == OP_PUSH_MIDDLE && n > 0) begin
               stored_values.insert(n / 2, value);
            end else begin
               // A middle push into an empty queue lands at the back as well.
               stored_values.insert(n, value);
            end
         end
         OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
            if (n == 0) begin
               outcome.status = ST_EMPTY;
               empty_count++;
            end else if (op == OP_POP_FRONT) begin
               outcome.popped_value = stored_values[0];
               stored_values.delete(0);
            end else if (op == OP_POP_MIDDLE) begin
               idx = (n - 1) / 2;
               outcome.popped_value = stored_values[idx];
               stored_values.delete(idx);
            end else begin
               idx = n - 1;
               outcome.popped_value = stored_values[idx];
               stored_values.delete(idx);
            end
         end
         default: begin
         end
      endcase
      if (stored_values.size() > peak_fill) begin
         peak_fill = stored_values.size();
      end
   endtask

   always @(posedge clock) begin : watch
      queue_result_type want;
      if (reset) begin
         stored_values.delete();
         owed_results.delete();
      end else begin
         // The request is booked first so that the oldest expectation is
         // still the one a response of this same edge belongs to.
         if (req_valid && !req_stall) begin
            apply_queue_op(req_opcode, req_data_value, want);
            owed_results.insert(owed_results.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = owed_results[0];
               owed_results.delete(0);
               checked_count++;
               if (rsp_popped_value !== want.popped_value) begin
                  report_mismatch($sformatf("popped value %0d, predicted %0d",
                                            rsp_popped_value, want.popped_value));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_status, want.status));
               end
            end
         end
      end
      owed_count = owed_results.size();
   end

endmodule

/* sim/front_middle_back_queue_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front/middle/back queue regression
// Drives directed and random requests into the queue with random idle and
// stall bursts on both channels; a checker beside the block predicts and
// compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------

module front_middle_back_queue_test;
   import fmbq_pkg::*;

   localparam int unsigned DEPTH = 64;

   // Opcodes six and seven are not in the package; the block treats them as
   // no operation and answers ok.
   localparam logic [2:0] OP_NOP_SIX   = 3'd6;
   localparam logic [2:0] OP_NOP_SEVEN = 3'd7;

   // Random queue operations, and how many of the last ones run with no
   // idling on either side.
   localparam int RANDOM_OPS    = 1830;
   localparam int CALM_OPS      = 200;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TIME_LIMIT_NS = 2_000_000;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic [2:0]               req_opcode     = '0;
   logic signed [DATA_W-1:0] req_data_value = '0;
   logic                     rsp_stall      = 1'b0;
   wire                      req_stall;
   wire                      rsp_valid;
   wire signed [DATA_W-1:0]  rsp_popped_value;
   wire        [1:0]         rsp_status;

   int fail_count;
   int owed_count;
   int checked_count;
   int empty_count;
   int full_count;
   int peak_fill;

   // Stimulus state; calm is shared with the receiver process.
   int   sent_count = 0;
   int   idle_pct   = 0;
   logic calm       = 1'b0;

   always #4 clock = ~clock;

   front_middle_back_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_data_value   (req_data_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status)
   );

   front_middle_back_queue_check #(
      .QUEUE_DEPTH(DEPTH)
   ) u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_data_value   (req_data_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .fail_count       (fail_count),
      .owed_count       (owed_count),
      .checked_count    (checked_count),
      .empty_count      (empty_count),
      .full_count       (full_count),
      .peak_fill        (peak_fill)
   );

   // Values lean on the corners: zero, minus one and both extremes show up
   // often, and the rest are uniform so that every bit toggles.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return {1'b0, {(DATA_W-1){1'b1}}};
         3: return {1'b1, {(DATA_W-1){1'b0}}};
         default: return $urandom();
      endcase
   endfunction

   // Sends one request and returns once it has been taken. An idle burst
   // may come first, unless the run is in its calm tail.
   // The valid is only lowered in a step where it is not also raised, and
   // the payload holds until the request is accepted.
   task automatic send_request(input logic [2:0] op,
                               input logic signed [DATA_W-1:0] value);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 6);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_data_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Holds the sender off until every outstanding response has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_count != 0) @(negedge clock);
   endtask

   // One random request. push_pct sets how strongly the queue is driven
   // toward full; a small share of requests use the two spare opcodes.
   // Returns one when the request was a real queue operation.
   task automatic send_random(input int push_pct, output int real_op);
      int         roll;
      logic [2:0] op;
      roll    = $urandom_range(0, 99);
      real_op = 1;
      if (roll < 2) begin
         op      = (roll == 0) ? OP_NOP_SIX : OP_NOP_SEVEN;
         real_op = 0;
      end else if (roll < 2 + push_pct) begin
         case ($urandom_range(0, 2))
            0: op = OP_PUSH_FRONT;
            1: op = OP_PUSH_MIDDLE;
            default: op = OP_PUSH_BACK;
         endcase
      end else begin
         case ($urandom_range(0, 2))
            0: op = OP_POP_FRONT;
            1: op = OP_POP_MIDDLE;
            default: op = OP_POP_BACK;
         endcase
      end
      // Pops carry a random value too; the block must ignore it.
      send_request(op, pick_value());
   endtask

   // Receiver side. The stall pressure switches between regimes, from none
   // at all to heavy, and comes in bursts. It is released for good in the
   // calm tail of the run.
   initial begin : receiver
      int stall_pct;
      int regime_left;
      int burst;
      stall_pct   = 0;
      regime_left = 0;
      burst       = 0;
      forever begin
         @(negedge clock);
         if (regime_left == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 15;
               default: stall_pct = 40;
            endcase
            regime_left = $urandom_range(50, 300);
         end
         regime_left--;
         if (calm) begin
            burst = 0;
            rsp_stall <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            burst = $urandom_range(1, 6) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int phase_left;
      int push_pct;
      int queue_ops;
      int real_op;
      int waited;
      phase_left = 0;
      push_pct   = 50;
      queue_ops  = 0;

      // Synchronous reset, released once.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Pops on the empty queue come first, from every end.
      idle_pct = 20;
      send_request(OP_POP_FRONT,  pick_value());
      send_request(OP_POP_MIDDLE, pick_value());
      send_request(OP_POP_BACK,   pick_value());
      // Middle push into an empty queue, then the value extremes at the front
      // and the back, with alternating bit patterns in the middle.
      send_request(OP_PUSH_MIDDLE, 32'sh1234_5678);
      send_request(OP_PUSH_BACK,   {1'b0, {(DATA_W-1){1'b1}}});
      send_request(OP_PUSH_FRONT,  {1'b1, {(DATA_W-1){1'b0}}});
      send_request(OP_PUSH_FRONT,  '0);
      send_request(OP_PUSH_BACK,   '1);
      send_request(OP_PUSH_MIDDLE, 32'sh5555_5555);
      send_request(OP_PUSH_MIDDLE, 32'shAAAA_AAAA);
      // The spare opcodes must leave the queue alone.
      send_request(OP_NOP_SIX,   pick_value());
      send_request(OP_NOP_SEVEN, pick_value());
      // Middle pops on even and odd sizes, then the two ends.
      send_request(OP_POP_MIDDLE, pick_value());
      send_request(OP_POP_MIDDLE, pick_value());
      send_request(OP_POP_FRONT,  pick_value());
      send_request(OP_POP_BACK,   pick_value());
      send_request(OP_POP_MIDDLE, pick_value());
      send_request(OP_POP_MIDDLE, pick_value());
      // A middle pop of the last entry, and one more pop on the empty queue.
      send_request(OP_POP_MIDDLE, pick_value());
      send_request(OP_POP_BACK,   pick_value());

      // The sender waits here until every response is back.
      wait_for_drain();

      // Random part, in phases that fill, drain or churn the queue. A fill
      // phase is long enough to reach full from empty and to hammer it.
      while (queue_ops < RANDOM_OPS) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  push_pct   = 85;
                  phase_left = $urandom_range(100, 200);
               end
               1: begin
                  push_pct   = 15;
                  phase_left = $urandom_range(60, 160);
               end
               default: begin
                  push_pct   = 49;
                  phase_left = $urandom_range(60, 160);
               end
            endcase
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 10;
               default: idle_pct = 35;
            endcase
         end
         phase_left--;
         if (queue_ops == RANDOM_OPS / 2) begin
            wait_for_drain();
         end
         calm = (queue_ops >= RANDOM_OPS - CALM_OPS);
         send_random(push_pct, real_op);
         queue_ops += real_op;
      end

      // All requests are in. Let the outstanding responses drain, then let
      // the pipeline settle to show any stray response.
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (owed_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (owed_count != 0) begin
         $display("%0d responses never arrived", owed_count);
      end
      $display("Covered %0d requests: every push and pop at each end and the middle,",
               sent_count);
      $display("spare opcodes, %0d empty pops, %0d full pushes, peak fill %0d of %0d.",
               empty_count, full_count, peak_fill, DEPTH);
      if (fail_count == 0 && owed_count == 0) begin
         $display("front_middle_back_queue regression: pass");
      end else begin
         $display("front_middle_back_queue regression: fail");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #(TIME_LIMIT_NS);
      $display("front_middle_back_queue regression: fail");
      $finish;
   end

endmodule

/* files.f */
src/fmbq_pkg.sv
src/fmbq_cell.sv
src/front_middle_back_queue.sv
sim/front_middle_back_queue_check.sv
sim/front_middle_back_queue_test.sv
